FILE: rtl/core/texture_best_fit_pool_macros.svh
// Assertion macros for the texture pool checker.
// The macros expect clk and arst_n in the scope where they are used.
`ifndef TEXTURE_BEST_FIT_POOL_MACROS_SVH
`define TEXTURE_BEST_FIT_POOL_MACROS_SVH

// Check that a property holds on every clock edge outside reset.
`define TBFP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("texture pool check failed");

// Check that a property holds on every clock edge, including during reset.
`define TBFP_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("texture pool check failed");

`endif

FILE: rtl/core/tbfp_pkg.sv
// ---------------------------------------------------------------------------
// tbfp_pkg
// Shared codes, command and status types for the texture best-fit pool.
// ---------------------------------------------------------------------------
`default_nettype none

package tbfp_pkg;

	// Request codes
	localparam logic [1:0] FN_ALLOC = 2'd0;
	localparam logic [1:0] FN_FREE  = 2'd1;
	localparam logic [1:0] FN_REL   = 2'd2;

	// Result action codes
	localparam logic [2:0] ACT_REUSE    = 3'd0;
	localparam logic [2:0] ACT_GROW     = 3'd1;
	localparam logic [2:0] ACT_NEW      = 3'd2;
	localparam logic [2:0] ACT_DISCARD  = 3'd3;
	localparam logic [2:0] ACT_FREED    = 3'd4;
	localparam logic [2:0] ACT_NOTFOUND = 3'd5;
	localparam logic [2:0] ACT_FULL     = 3'd6;
	localparam logic [2:0] ACT_NOTHING  = 3'd7;

	// Kind of result item the datapath loads into its output register
	typedef enum logic [3:0] {
		EM_NONE,
		EM_FULL_ALLOC,
		EM_REUSE,
		EM_GROW,
		EM_NEW,
		EM_FREED,
		EM_NOTFOUND,
		EM_FULL_FREE,
		EM_DISCARD,
		EM_NOTHING
	} emit_t;

	typedef struct packed {
		logic  latch;
		logic  scan_init;
		logic  scan_rd;
		logic  scan_cmp;
		logic  srch_init;
		logic  srch_step;
		logic  rel_init;
		logic  rel_next;
		emit_t emit;
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       used_full;
		logic       free_full;
		logic       both_empty;
		logic       scan_end;
		logic       reuse;
		logic       grow;
		logic       ptr_zero;
		logic       hit;
		logic       rel_last;
		logic       out_busy;
	} status_t;

endpackage

`default_nettype wire

FILE: rtl/core/tbfp_ctrl.sv
// ---------------------------------------------------------------------------
// tbfp_ctrl
// Sequencer for the texture pool: decodes a request, steps the scans and
// picks the kind of each result item.
// ---------------------------------------------------------------------------
`default_nettype none

module tbfp_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire tbfp_pkg::status_t sts,
	output tbfp_pkg::cmd_t       cmd
);
	import tbfp_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_A_RD,
		ST_A_CMP,
		ST_A_DEC,
		ST_F_CHK,
		ST_R_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rdy_q;

	assign in_ready = rdy_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.emit = EM_NONE;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && rdy_q) begin
					cmd.latch = 1'b1;
					state_d   = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (sts.func)
					FN_ALLOC: begin
						if (sts.used_full) begin
							if (!sts.out_busy) begin
								cmd.emit = EM_FULL_ALLOC;
								state_d  = ST_IDLE;
							end
						end else begin
							cmd.scan_init = 1'b1;
							state_d       = ST_A_RD;
						end
					end
					FN_FREE: begin
						cmd.srch_init = 1'b1;
						state_d       = ST_F_CHK;
					end
					FN_REL: begin
						if (sts.both_empty) begin
							if (!sts.out_busy) begin
								cmd.emit = EM_NOTHING;
								state_d  = ST_IDLE;
							end
						end else begin
							cmd.rel_init = 1'b1;
							state_d      = ST_R_EMIT;
						end
					end
					default: begin
						if (!sts.out_busy) begin
							cmd.emit = EM_NOTHING;
							state_d  = ST_IDLE;
						end
					end
				endcase
			end
			ST_A_RD: begin
				if (sts.scan_end) begin
					state_d = ST_A_DEC;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d     = ST_A_CMP;
				end
			end
			ST_A_CMP: begin
				cmd.scan_cmp = 1'b1;
				state_d      = ST_A_RD;
			end
			ST_A_DEC: begin
				if (!sts.out_busy) begin
					if (sts.reuse)
						cmd.emit = EM_REUSE;
					else if (sts.grow)
						cmd.emit = EM_GROW;
					else
						cmd.emit = EM_NEW;
					state_d = ST_IDLE;
				end
			end
			ST_F_CHK: begin
				if (sts.ptr_zero || sts.hit) begin
					if (!sts.out_busy) begin
						if (sts.ptr_zero)
							cmd.emit = EM_NOTFOUND;
						else if (sts.free_full)
							cmd.emit = EM_FULL_FREE;
						else
							cmd.emit = EM_FREED;
						state_d = ST_IDLE;
					end
				end else begin
					cmd.srch_step = 1'b1;
				end
			end
			ST_R_EMIT: begin
				if (!sts.out_busy) begin
					cmd.emit = EM_DISCARD;
					if (sts.rel_last)
						state_d = ST_IDLE;
					else
						cmd.rel_next = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold state and the registered ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rdy_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			rdy_q   <= (state_d == ST_IDLE);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/tbfp_dp.sv
// ---------------------------------------------------------------------------
// tbfp_dp
// Datapath of the texture pool: free and used lists, best-fit scan unit,
// handle search and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module tbfp_dp #(
	parameter int FREE_DEPTH = 16,
	parameter int USED_DEPTH = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [1:0]    func,
	input  wire logic [15:0]   req_width,
	input  wire logic [15:0]   req_height,
	input  wire logic [7:0]    type_code,
	input  wire logic [31:0]   fresh_handle,
	input  wire logic [31:0]   free_handle_in,
	input  wire tbfp_pkg::cmd_t cmd,
	output tbfp_pkg::status_t  sts,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [2:0]         action,
	output logic [31:0]        out_handle,
	output logic [31:0]        old_handle,
	output logic [15:0]        out_width,
	output logic [15:0]        out_height,
	output logic               last
);
	import tbfp_pkg::*;

	localparam int FIW = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
	localparam int FCW = $clog2(FREE_DEPTH + 1);
	localparam int UIW = (USED_DEPTH > 1) ? $clog2(USED_DEPTH) : 1;
	localparam int UCW = $clog2(USED_DEPTH + 1);

	// Request registers
	logic [1:0]  func_q;
	logic [15:0] rw_q;
	logic [15:0] rh_q;
	logic [7:0]  t_q;
	logic [31:0] fh_q;
	logic [31:0] hin_q;
	logic [31:0] req_q;

	// Lists
	logic [31:0] fl_h_q [FREE_DEPTH];
	logic [15:0] fl_w_q [FREE_DEPTH];
	logic [15:0] fl_ht_q[FREE_DEPTH];
	logic [7:0]  fl_t_q [FREE_DEPTH];
	logic [FCW-1:0] free_cnt_q;
	logic [31:0] ul_h_q [USED_DEPTH];
	logic [39:0] ul_s_q [USED_DEPTH];
	logic [UCW-1:0] used_cnt_q;

	// Scan and search pointers
	logic [FCW-1:0] sidx_q;
	logic [UCW-1:0] ptr_q;
	logic           rphase_q;

	// Scan stage and best entry
	logic        match_s1;
	logic [15:0] nw_s1;
	logic [15:0] nh_s1;
	logic [31:0] nsz_s1;
	logic [31:0] osz_s1;
	logic        found_q;
	logic [31:0] min_add_q;
	logic [31:0] min_waste_q;
	logic [FIW-1:0] best_idx_q;
	logic [31:0] best_h_q;
	logic [15:0] best_w_q;
	logic [15:0] best_ht_q;
	logic [15:0] best_nw_q;
	logic [15:0] best_nh_q;

	logic           out_valid_q;

	// Read ports
	logic [FIW-1:0] fidx;
	logic [UCW-1:0] ptr_m1;
	logic [UIW-1:0] uidx;
	logic [31:0]    f_h_rd;
	logic [15:0]    f_w_rd;
	logic [15:0]    f_ht_rd;
	logic [7:0]     f_t_rd;
	logic [31:0]    u_h_rd;
	logic [39:0]    u_s_rd;
	logic [15:0]    nw_c;
	logic [15:0]    nh_c;
	logic [31:0]    add_c;
	logic [31:0]    waste_c;
	logic           upd_c;
	logic           rel_last_c;

	assign fidx    = sidx_q[FIW-1:0];
	assign ptr_m1  = ptr_q - UCW'(1);
	assign uidx    = ptr_m1[UIW-1:0];
	assign f_h_rd  = fl_h_q[fidx];
	assign f_w_rd  = fl_w_q[fidx];
	assign f_ht_rd = fl_ht_q[fidx];
	assign f_t_rd  = fl_t_q[fidx];
	assign u_h_rd  = ul_h_q[uidx];
	assign u_s_rd  = ul_s_q[uidx];

	// Grown size of the entry under the scan pointer
	assign nw_c = (f_w_rd > rw_q) ? f_w_rd : rw_q;
	assign nh_c = (f_ht_rd > rh_q) ? f_ht_rd : rh_q;

	// Compare the registered areas against the best so far
	assign add_c   = nsz_s1 - osz_s1;
	assign waste_c = nsz_s1 - req_q;
	assign upd_c   = match_s1 && (!found_q
		|| (min_add_q != 32'd0 && add_c < min_add_q)
		|| (min_add_q == 32'd0 && waste_c < min_waste_q));

	// Last discard item of a release
	assign rel_last_c = rphase_q ? (sidx_q + FCW'(1) == free_cnt_q)
		: (ptr_q == used_cnt_q && free_cnt_q == '0);

	// Status to the controller
	always_comb begin
		sts.func       = func_q;
		sts.used_full  = (used_cnt_q == UCW'(USED_DEPTH));
		sts.free_full  = (free_cnt_q == FCW'(FREE_DEPTH));
		sts.both_empty = (used_cnt_q == '0) && (free_cnt_q == '0);
		sts.scan_end   = (sidx_q >= free_cnt_q);
		sts.reuse      = found_q && (min_add_q == 32'd0);
		sts.grow       = found_q && (min_add_q <= req_q);
		sts.ptr_zero   = (ptr_q == '0);
		sts.hit        = (ptr_q != '0) && (u_h_rd == hin_q);
		sts.rel_last   = rel_last_c;
		sts.out_busy   = out_valid_q;
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q <= func;
			rw_q   <= req_width;
			rh_q   <= req_height;
			t_q    <= type_code;
			fh_q   <= fresh_handle;
			hin_q  <= free_handle_in;
			req_q  <= 32'(req_width) * 32'(req_height);
		end
	end

	// Scan stage: grown and old areas of one entry
	always_ff @(posedge clk) begin
		if (cmd.scan_rd) begin
			match_s1 <= (f_t_rd == t_q);
			nw_s1    <= nw_c;
			nh_s1    <= nh_c;
			nsz_s1   <= 32'(nw_c) * 32'(nh_c);
			osz_s1   <= 32'(f_w_rd) * 32'(f_ht_rd);
		end
	end

	// Keep the best entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.scan_init) begin
			found_q <= 1'b0;
		end else if (cmd.scan_cmp && upd_c) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_cmp && upd_c) begin
			min_add_q   <= add_c;
			min_waste_q <= waste_c;
			best_idx_q  <= fidx;
			best_h_q    <= f_h_rd;
			best_w_q    <= f_w_rd;
			best_ht_q   <= f_ht_rd;
			best_nw_q   <= nw_s1;
			best_nh_q   <= nh_s1;
		end
	end

	// Advance the pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sidx_q   <= '0;
			ptr_q    <= '0;
			rphase_q <= 1'b0;
		end else begin
			if (cmd.scan_init || cmd.rel_init)
				sidx_q <= '0;
			else if (cmd.scan_cmp || (cmd.rel_next && rphase_q))
				sidx_q <= sidx_q + FCW'(1);
			if (cmd.srch_init)
				ptr_q <= used_cnt_q;
			else if (cmd.rel_init)
				ptr_q <= UCW'(1);
			else if (cmd.srch_step)
				ptr_q <= ptr_m1;
			else if (cmd.rel_next && !rphase_q && ptr_q != used_cnt_q)
				ptr_q <= ptr_q + UCW'(1);
			if (cmd.rel_init)
				rphase_q <= (used_cnt_q == '0);
			else if (cmd.rel_next && ptr_q == used_cnt_q)
				rphase_q <= 1'b1;
		end
	end

	// Update list counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_cnt_q <= '0;
			used_cnt_q <= '0;
		end else begin
			case (cmd.emit)
				EM_REUSE, EM_GROW: begin
					free_cnt_q <= free_cnt_q - FCW'(1);
					used_cnt_q <= used_cnt_q + UCW'(1);
				end
				EM_NEW: begin
					used_cnt_q <= used_cnt_q + UCW'(1);
				end
				EM_FREED: begin
					free_cnt_q <= free_cnt_q + FCW'(1);
					used_cnt_q <= used_cnt_q - UCW'(1);
				end
				EM_DISCARD: begin
					if (rel_last_c) begin
						free_cnt_q <= '0;
						used_cnt_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Free list: drop the best entry, or append a freed one
	always_ff @(posedge clk) begin
		if (cmd.emit == EM_REUSE || cmd.emit == EM_GROW) begin
			for (int i = 0; i < FREE_DEPTH - 1; i++) begin
				if (FIW'(i) >= best_idx_q) begin
					fl_h_q[i]  <= fl_h_q[i+1];
					fl_w_q[i]  <= fl_w_q[i+1];
					fl_ht_q[i] <= fl_ht_q[i+1];
					fl_t_q[i]  <= fl_t_q[i+1];
				end
			end
		end else if (cmd.emit == EM_FREED) begin
			fl_h_q[free_cnt_q[FIW-1:0]]  <= hin_q;
			fl_w_q[free_cnt_q[FIW-1:0]]  <= u_s_rd[15:0];
			fl_ht_q[free_cnt_q[FIW-1:0]] <= u_s_rd[31:16];
			fl_t_q[free_cnt_q[FIW-1:0]]  <= u_s_rd[39:32];
		end
	end

	// Used list: append a granted entry, or drop a freed one
	always_ff @(posedge clk) begin
		case (cmd.emit)
			EM_REUSE: begin
				ul_h_q[used_cnt_q[UIW-1:0]] <= best_h_q;
				ul_s_q[used_cnt_q[UIW-1:0]] <= {t_q, best_ht_q, best_w_q};
			end
			EM_GROW: begin
				ul_h_q[used_cnt_q[UIW-1:0]] <= fh_q;
				ul_s_q[used_cnt_q[UIW-1:0]] <= {t_q, best_nh_q, best_nw_q};
			end
			EM_NEW: begin
				ul_h_q[used_cnt_q[UIW-1:0]] <= fh_q;
				ul_s_q[used_cnt_q[UIW-1:0]] <= {t_q, rh_q, rw_q};
			end
			EM_FREED: begin
				for (int i = 0; i < USED_DEPTH - 1; i++) begin
					if (UIW'(i) >= uidx) begin
						ul_h_q[i] <= ul_h_q[i+1];
						ul_s_q[i] <= ul_s_q[i+1];
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: hold until the receiver takes the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit != EM_NONE) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit != EM_NONE) begin
			old_handle <= 32'd0;
			out_width  <= 16'd0;
			out_height <= 16'd0;
			last       <= 1'b1;
			out_handle <= 32'd0;
			action     <= ACT_NOTHING;
			case (cmd.emit)
				EM_FULL_ALLOC: begin
					action     <= ACT_FULL;
					out_handle <= fh_q;
				end
				EM_REUSE: begin
					action     <= ACT_REUSE;
					out_handle <= best_h_q;
					out_width  <= best_w_q;
					out_height <= best_ht_q;
				end
				EM_GROW: begin
					action     <= ACT_GROW;
					out_handle <= fh_q;
					old_handle <= best_h_q;
					out_width  <= best_nw_q;
					out_height <= best_nh_q;
				end
				EM_NEW: begin
					action     <= ACT_NEW;
					out_handle <= fh_q;
					out_width  <= rw_q;
					out_height <= rh_q;
				end
				EM_FREED: begin
					action     <= ACT_FREED;
					out_handle <= hin_q;
					out_width  <= u_s_rd[15:0];
					out_height <= u_s_rd[31:16];
				end
				EM_NOTFOUND: begin
					action     <= ACT_NOTFOUND;
					out_handle <= hin_q;
				end
				EM_FULL_FREE: begin
					action     <= ACT_FULL;
					out_handle <= hin_q;
				end
				EM_DISCARD: begin
					action     <= ACT_DISCARD;
					out_handle <= rphase_q ? f_h_rd : u_h_rd;
					last       <= rel_last_c;
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/core/texture_best_fit_pool.sv
// Texture best-fit pool.
// Input channel (in_valid/in_ready) takes one request: allocate, free or
// release. Output channel (out_valid/out_ready) returns result items; the
// last field marks the final item of a request.
// Allocate scans the free list one entry at a time: it first registers the
// area multiplies, then compares them with the best entry so far.
// Free searches the used list from its newest entry, one entry a cycle.
// Release gives U+F discard items with U used and F free entries, or one
// nothing item when both lists are empty; an item is loaded only once the
// output register is empty, so the next item is never loaded while the
// previous one is still held.
// A new request is taken once the previous one has produced all its items;
// the last item may still sit in the output register at that time.
// Reset empties both lists and drops any pending item. When the receiver
// stalls, the output register holds its item and the sequencer waits
// before loading the next one; no item is lost.
// ---------------------------------------------------------------------------
// texture_best_fit_pool
// Top level: sequencer and datapath of the best-fit texture buffer pool.
// ---------------------------------------------------------------------------
`default_nettype none

module texture_best_fit_pool #(
	parameter int FREE_DEPTH = 16,
	parameter int USED_DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  func,
	input  wire logic [15:0] req_width,
	input  wire logic [15:0] req_height,
	input  wire logic [7:0]  type_code,
	input  wire logic [31:0] fresh_handle,
	input  wire logic [31:0] free_handle_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       action,
	output logic [31:0]      out_handle,
	output logic [31:0]      old_handle,
	output logic [15:0]      out_width,
	output logic [15:0]      out_height,
	output logic             last
);
	import tbfp_pkg::*;

	cmd_t    cmd;
	status_t sts;

	// Sequencer
	tbfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Lists, scan unit and output register
	tbfp_dp #(
		.FREE_DEPTH (FREE_DEPTH),
		.USED_DEPTH (USED_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.func           (func),
		.req_width      (req_width),
		.req_height     (req_height),
		.type_code      (type_code),
		.fresh_handle   (fresh_handle),
		.free_handle_in (free_handle_in),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.action         (action),
		.out_handle     (out_handle),
		.old_handle     (old_handle),
		.out_width      (out_width),
		.out_height     (out_height),
		.last           (last)
	);

endmodule

`default_nettype wire

FILE: rtl/core/tbfp_checker.sv
// ---------------------------------------------------------------------------
// tbfp_checker
// Port-level checks on the texture pool, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "texture_best_fit_pool_macros.svh"

module tbfp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  action,
	input wire logic [31:0] old_handle,
	input wire logic        last
);
	import tbfp_pkg::*;

	// A pending item stays until taken
	`TBFP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)

	// Only release items may be followed by more items of the same request
	`TBFP_ASSERT(a_single_last, out_valid && action != ACT_DISCARD |-> last)

	// An old handle is reported only when an entry grows
	`TBFP_ASSERT(a_old_grow, out_valid && action != ACT_GROW |-> old_handle == 32'd0)

	// One request at a time
	`TBFP_ASSERT(a_one_req, in_valid && in_ready |=> !in_ready)

	// Nothing is offered in reset
	`TBFP_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !out_valid && !in_ready)

endmodule

bind texture_best_fit_pool tbfp_checker u_tbfp_checker (.*);

`default_nettype wire
